// File: hdl/png_scanline_unfilter_assert.svh
// Assertion macros shared by the png_scanline_unfilter checker.
// Depends on nothing; take in with a plain include.
`ifndef PNG_SCANLINE_UNFILTER_ASSERT_SVH
`define PNG_SCANLINE_UNFILTER_ASSERT_SVH

// Check on every rising edge outside reset.
`define UNF_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("png_scanline_unfilter assertion failed");

// Check on every rising edge, reset included.
`define UNF_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("png_scanline_unfilter assertion failed");

`endif

// File: hdl/unf_pkg.sv
// Shared types and constants for the PNG scanline unfilter.
// Depends on nothing; used by the front end, back end, top level and checker.
package unf_pkg;

    localparam int MAX_ROW_BYTES_DEFAULT = 8192;
    localparam int COL_W                 = 16;
    localparam int CFG_W                 = 14;

    localparam logic [13:0] ROW_BYTES_RESET = 14'd3;
    localparam logic [2:0]  BPP_RESET       = 3'd3;

    localparam logic REG_ROW_BYTES       = 1'b0;
    localparam logic REG_BYTES_PER_PIXEL = 1'b1;

    localparam logic [7:0] FILTER_NONE = 8'd0;
    localparam logic [7:0] FILTER_SUB  = 8'd1;
    localparam logic [7:0] FILTER_UP   = 8'd2;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_SUB,
        OP_UP,
        OP_RAW
    } filt_op_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       image_start;
    } in_item_t;

    typedef struct packed {
        logic [7:0] pixel_byte;
        logic       row_end;
        logic       unsupported_filter;
    } out_item_t;

    typedef struct packed {
        logic [7:0]       data_byte;
        filt_op_t         op;
        logic [COL_W-1:0] col;
        logic             last;
        logic             first_row;
        logic             row_first;
    } unf_op_t;

endpackage

// File: hdl/unf_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module unf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8192
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: hdl/unf_fifo.sv
// Small register FIFO used between the unfilter stages and at the output.
// Depends on nothing.
module unf_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             full,
    output logic             empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] store [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = store[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            store[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: hdl/unf_front.sv
// Front end: accepts stream bytes, tracks row position and classifies filter bytes.
// Depends on unf_pkg.
module unf_front #(
    parameter int MAX_ROW_BYTES = unf_pkg::MAX_ROW_BYTES_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  unf_pkg::in_item_t in_data,
    input  logic [13:0]       row_bytes,
    output logic              q_push,
    output unf_pkg::unf_op_t  q_data
);

    import unf_pkg::*;

    localparam int ADDR_W = $clog2(MAX_ROW_BYTES);
    localparam int LEN_W  = $clog2(MAX_ROW_BYTES + 1);

    logic [ADDR_W-1:0] column_reg, column_next;
    filt_op_t          op_reg, op_next;
    logic              await_reg, await_next;
    logic              first_row_reg, first_row_next;
    logic              row_first_reg, row_first_next;

    logic [LEN_W-1:0]  len_eff;
    logic [ADDR_W-1:0] len_m1;
    logic [ADDR_W-1:0] col;
    logic              at_end;
    logic              is_filter;
    filt_op_t          op_class;

    always_comb
    begin
        if (row_bytes == '0)
        begin
            len_eff = LEN_W'(1);
        end
        else if (32'(row_bytes) > 32'(MAX_ROW_BYTES))
        begin
            len_eff = LEN_W'(MAX_ROW_BYTES);
        end
        else
        begin
            len_eff = LEN_W'(row_bytes);
        end
    end

    assign len_m1    = ADDR_W'(len_eff - LEN_W'(1));
    assign at_end    = (column_reg >= len_m1);
    assign col       = at_end ? len_m1 : column_reg;
    assign is_filter = in_data.image_start || await_reg;

    always_comb
    begin
        case (in_data.data_byte)
            FILTER_NONE: op_class = OP_NONE;
            FILTER_SUB:  op_class = OP_SUB;
            FILTER_UP:   op_class = OP_UP;
            default:     op_class = OP_RAW;
        endcase
    end

    assign q_push           = accept && !is_filter;
    assign q_data.data_byte = in_data.data_byte;
    assign q_data.op        = op_reg;
    assign q_data.col       = COL_W'(col);
    assign q_data.last      = at_end;
    assign q_data.first_row = first_row_reg;
    assign q_data.row_first = row_first_reg;

    always_comb
    begin
        column_next    = column_reg;
        op_next        = op_reg;
        await_next     = await_reg;
        first_row_next = first_row_reg;
        row_first_next = row_first_reg;
        if (accept)
        begin
            if (is_filter)
            begin
                op_next        = op_class;
                column_next    = '0;
                await_next     = 1'b0;
                row_first_next = 1'b1;
                if (in_data.image_start)
                begin
                    first_row_next = 1'b1;
                end
            end
            else
            begin
                row_first_next = 1'b0;
                if (at_end)
                begin
                    column_next    = '0;
                    await_next     = 1'b1;
                    first_row_next = 1'b0;
                end
                else
                begin
                    column_next = col + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_reg    <= '0;
            op_reg        <= OP_NONE;
            await_reg     <= 1'b1;
            first_row_reg <= 1'b1;
            row_first_reg <= 1'b1;
        end
        else
        begin
            column_reg    <= column_next;
            op_reg        <= op_next;
            await_reg     <= await_next;
            first_row_reg <= first_row_next;
            row_first_reg <= row_first_next;
        end
    end

endmodule

// File: hdl/unf_back.sv
// Back end: reads the row above, reconstructs each data byte and updates history.
// Depends on unf_pkg and unf_ram.
module unf_back #(
    parameter int MAX_ROW_BYTES = unf_pkg::MAX_ROW_BYTES_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_empty,
    input  unf_pkg::unf_op_t   q_data,
    output logic               q_pop,
    input  logic [1:0]         bpp_sel,
    input  logic               o_full,
    output logic               o_push,
    output unf_pkg::out_item_t o_data
);

    import unf_pkg::*;

    localparam int ADDR_W = $clog2(MAX_ROW_BYTES);

    logic       b1_valid_reg, b1_valid_next;
    unf_op_t    b1_op_reg, b1_op_next;
    logic       fwd_reg, fwd_next;
    logic [7:0] fwd_data_reg, fwd_data_next;
    logic [31:0] hist_reg, hist_next;

    logic       adv, load;
    logic [7:0] rd_data, above, left, value;

    assign adv   = b1_valid_reg && !o_full;
    assign load  = !q_empty && (!b1_valid_reg || adv);
    assign q_pop = load;

    unf_ram #(
        .WIDTH (8),
        .DEPTH (MAX_ROW_BYTES)
    ) u_line_store (
        .clk     (clk),
        .wr_en   (adv),
        .wr_addr (b1_op_reg.col[ADDR_W-1:0]),
        .wr_data (value),
        .rd_en   (load),
        .rd_addr (q_data.col[ADDR_W-1:0]),
        .rd_data (rd_data)
    );

    assign above = b1_op_reg.first_row ? 8'd0 : (fwd_reg ? fwd_data_reg : rd_data);
    assign left  = b1_op_reg.row_first ? 8'd0 : hist_reg[{bpp_sel, 3'b000} +: 8];

    always_comb
    begin
        case (b1_op_reg.op)
            OP_NONE: value = b1_op_reg.data_byte;
            OP_SUB:  value = b1_op_reg.data_byte + left;
            OP_UP:   value = b1_op_reg.data_byte + above;
            default: value = b1_op_reg.data_byte;
        endcase
    end

    assign o_push                    = adv;
    assign o_data.pixel_byte         = value;
    assign o_data.row_end            = b1_op_reg.last;
    assign o_data.unsupported_filter = (b1_op_reg.op == OP_RAW);

    always_comb
    begin
        b1_valid_next = b1_valid_reg;
        b1_op_next    = b1_op_reg;
        fwd_next      = fwd_reg;
        fwd_data_next = fwd_data_reg;
        hist_next     = hist_reg;
        if (adv)
        begin
            b1_valid_next = 1'b0;
            hist_next = b1_op_reg.row_first ? {24'd0, value} : {hist_reg[23:0], value};
        end
        if (load)
        begin
            b1_valid_next = 1'b1;
            b1_op_next    = q_data;
            // take the byte being written this cycle when the addresses collide
            fwd_next      = adv && (b1_op_reg.col == q_data.col);
            fwd_data_next = value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_valid_reg <= 1'b0;
            fwd_reg      <= 1'b0;
            hist_reg     <= '0;
        end
        else
        begin
            b1_valid_reg <= b1_valid_next;
            fwd_reg      <= fwd_next;
            hist_reg     <= hist_next;
        end
    end

    always_ff @(posedge clk)
    begin
        b1_op_reg    <= b1_op_next;
        fwd_data_reg <= fwd_data_next;
    end

endmodule

// File: hdl/png_scanline_unfilter.sv
// PNG scanline unfilter, None/Sub/Up reconstruction, top level.
// A data byte passes through the op queue, the back-end stage register and the output queue in that order.
// Throughput: one byte per cycle while full stays low, filter bytes included; the line store's one write
// and one read port per cycle set that figure. Filter bytes give no result.
// Reset (rst_n, async, active low) returns control state and the configuration
// registers to their reset values; the line store is not cleared and needs no clearing pass.
module png_scanline_unfilter #(
    parameter int MAX_ROW_BYTES = unf_pkg::MAX_ROW_BYTES_DEFAULT
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     push,
    output logic                     full,
    input  unf_pkg::in_item_t        in_data,
    output logic                     empty,
    input  logic                     pop,
    output unf_pkg::out_item_t       out_data,
    input  logic                     wr_en,
    input  logic                     wr_index,
    input  logic [unf_pkg::CFG_W-1:0] wr_data
);

    import unf_pkg::*;

    localparam int OP_W  = $bits(unf_op_t);
    localparam int OUT_W = $bits(out_item_t);

    logic [13:0] row_bytes_reg, row_bytes_next;
    logic [2:0]  bpp_reg, bpp_next;
    logic [1:0]  bpp_sel;

    logic      accept;
    logic      fq_push, fq_pop, fq_full, fq_empty;
    unf_op_t   fq_in, fq_out;
    logic      oq_push, oq_full;
    out_item_t oq_in;

    assign accept = push && !full;
    assign full   = fq_full;

    always_comb
    begin
        row_bytes_next = row_bytes_reg;
        bpp_next       = bpp_reg;
        if (wr_en)
        begin
            case (wr_index)
                REG_ROW_BYTES:       row_bytes_next = wr_data[13:0];
                REG_BYTES_PER_PIXEL: bpp_next       = wr_data[2:0];
                default:             row_bytes_next = row_bytes_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_bytes_reg <= ROW_BYTES_RESET;
            bpp_reg       <= BPP_RESET;
        end
        else
        begin
            row_bytes_reg <= row_bytes_next;
            bpp_reg       <= bpp_next;
        end
    end

    assign bpp_sel = (bpp_reg == 3'd0) ? 2'd0 :
                     (bpp_reg > 3'd4)  ? 2'd3 : 2'(bpp_reg - 3'd1);

    unf_front #(
        .MAX_ROW_BYTES (MAX_ROW_BYTES)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .in_data   (in_data),
        .row_bytes (row_bytes_reg),
        .q_push    (fq_push),
        .q_data    (fq_in)
    );

    unf_fifo #(
        .WIDTH (OP_W),
        .DEPTH (4)
    ) u_op_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (fq_push),
        .push_data (fq_in),
        .pop       (fq_pop),
        .pop_data  (fq_out),
        .full      (fq_full),
        .empty     (fq_empty)
    );

    unf_back #(
        .MAX_ROW_BYTES (MAX_ROW_BYTES)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (fq_empty),
        .q_data  (fq_out),
        .q_pop   (fq_pop),
        .bpp_sel (bpp_sel),
        .o_full  (oq_full),
        .o_push  (oq_push),
        .o_data  (oq_in)
    );

    unf_fifo #(
        .WIDTH (OUT_W),
        .DEPTH (2)
    ) u_out_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (oq_push),
        .push_data (oq_in),
        .pop       (pop),
        .pop_data  (out_data),
        .full      (oq_full),
        .empty     (empty)
    );

endmodule

// File: hdl/unf_chk.sv
// Port-level checker for png_scanline_unfilter, attached by bind.
// Depends on unf_pkg and png_scanline_unfilter_assert.svh.
`include "png_scanline_unfilter_assert.svh"

module unf_chk (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      push,
    input logic                      full,
    input unf_pkg::in_item_t         in_data,
    input logic                      empty,
    input logic                      pop,
    input unf_pkg::out_item_t        out_data,
    input logic                      wr_en,
    input logic                      wr_index,
    input logic [unf_pkg::CFG_W-1:0] wr_data
);

    import unf_pkg::*;

    logic cfg_seen;
    logic in_seen;

    assign cfg_seen = wr_en && (wr_index == REG_ROW_BYTES || wr_index == REG_BYTES_PER_PIXEL);
    assign in_seen  = push || in_data.image_start || (wr_data != '0) || cfg_seen;

    `UNF_ASSERT_ALWAYS(a_reset_queues_clear, clk, !rst_n |=> (empty && !full))
    `UNF_ASSERT(a_result_holds, clk, rst_n, (!empty && !pop) |=> (!empty && $stable(out_data)))
    `UNF_ASSERT(a_full_needs_push, clk, rst_n, $rose(full) |-> $past(push))
    `UNF_ASSERT(a_full_only_after_input, clk, rst_n, $rose(full) |-> $past(in_seen))

endmodule

bind png_scanline_unfilter unf_chk u_chk (.*);
